// ===== rtl/tensor_roll_address_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tensor roll address generator
// Shared property shorthands, clocked on clk and gated by the active-low reset.
// ----------------------------------------------------------------------------
`ifndef TENSOR_ROLL_ADDRESS_GENERATOR_DEFINES_SVH
`define TENSOR_ROLL_ADDRESS_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRAG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRAG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/trag_pkg.sv =====
// ----------------------------------------------------------------------------
// trag_pkg
// Register indexes, fixed field widths and shared types of the roll address
// generator.
// ----------------------------------------------------------------------------
package trag_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int STRIDE_W    = 32;
  localparam int POS_W       = 32;
  localparam int OUT_OFS_W   = 32;
  localparam int NUM_STRIDES = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFTS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_3 = 3'd5;

  // Step control handed to every odometer digit.
  typedef struct packed {
    logic step;
    logic restart;
  } trag_ctl_t;

endpackage

// ===== rtl/trag_digit.sv =====
// ----------------------------------------------------------------------------
// trag_digit
// One odometer digit: holds the output coordinate and the matching source
// coordinate of one dimension and advances when all faster digits are full.
// ----------------------------------------------------------------------------
module trag_digit #(
  parameter int DIM_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  trag_pkg::trag_ctl_t  ctl,
  input  logic                 load_en,
  input  logic [DIM_WIDTH-1:0] load_src,
  input  logic [DIM_WIDTH-1:0] load_zsrc,
  input  logic [DIM_WIDTH-1:0] size,
  input  logic                 low_full_in,
  output logic                 full_out,
  output logic [DIM_WIDTH-1:0] coord,
  output logic [DIM_WIDTH-1:0] cur_src
);

  logic [DIM_WIDTH-1:0] coord_r, coord_nxt;
  logic [DIM_WIDTH-1:0] src_r, src_nxt;
  logic [DIM_WIDTH-1:0] zsrc_r, zsrc_nxt;
  logic [DIM_WIDTH-1:0] cur_coord;
  logic [DIM_WIDTH:0]   coord_inc;
  logic [DIM_WIDTH:0]   src_inc;
  logic                 full;

  assign coord = coord_r;

  always_comb begin
    cur_coord = ctl.restart ? '0 : coord_r;
    cur_src   = ctl.restart ? zsrc_r : src_r;
    coord_inc = {1'b0, cur_coord} + {{DIM_WIDTH{1'b0}}, 1'b1};
    src_inc   = {1'b0, cur_src} + {{DIM_WIDTH{1'b0}}, 1'b1};
    // A coordinate left above its size by a size change counts as full.
    full      = coord_inc >= {1'b0, size};
    full_out  = low_full_in & full;

    coord_nxt = coord_r;
    src_nxt   = src_r;
    zsrc_nxt  = zsrc_r;
    if (load_en) begin
      src_nxt  = load_src;
      zsrc_nxt = load_zsrc;
    end else if (ctl.step) begin
      if (!low_full_in) begin
        coord_nxt = cur_coord;
        src_nxt   = cur_src;
      end else if (full) begin
        coord_nxt = '0;
        src_nxt   = zsrc_r;
      end else begin
        coord_nxt = coord_inc[DIM_WIDTH-1:0];
        src_nxt   = (src_inc == {1'b0, size}) ? '0 : src_inc[DIM_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_r <= '0;
      src_r   <= '0;
      zsrc_r  <= '0;
    end else begin
      coord_r <= coord_nxt;
      src_r   <= src_nxt;
      zsrc_r  <= zsrc_nxt;
    end
  end

endmodule

// ===== rtl/trag_norm.sv =====
// ----------------------------------------------------------------------------
// trag_norm
// Renormalizer run after a size or shift write: for each dimension it reduces
// the shift and the current coordinate modulo the size, one bit per cycle,
// and reloads the digit's source coordinate and its restart value.
// ----------------------------------------------------------------------------
module trag_norm #(
  parameter int MAX_DIMS  = 4,
  parameter int DIM_WIDTH = 16,
  parameter int DIM_IDX_W = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [MAX_DIMS*DIM_WIDTH-1:0] sizes,
  input  logic [MAX_DIMS*DIM_WIDTH-1:0] shifts,
  input  logic [MAX_DIMS*DIM_WIDTH-1:0] coords,
  output logic                          busy,
  output logic                          wr_en,
  output logic [DIM_IDX_W-1:0]          wr_dim,
  output logic [DIM_WIDTH-1:0]          wr_src,
  output logic [DIM_WIDTH-1:0]          wr_zsrc
);

  localparam int CNT_W = $clog2(DIM_WIDTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOAD  = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [DIM_IDX_W-1:0] dim_r, dim_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIM_WIDTH-1:0] div_r, sa_r, ca_r, rs_r, rc_r;
  logic [DIM_WIDTH:0]   rs_try, rc_try, rs_sub, rc_sub;
  logic [DIM_WIDTH-1:0] rs_step, rc_step;

  always_comb begin
    rs_try  = {rs_r, sa_r[DIM_WIDTH-1]};
    rc_try  = {rc_r, ca_r[DIM_WIDTH-1]};
    rs_sub  = rs_try - {1'b0, div_r};
    rc_sub  = rc_try - {1'b0, div_r};
    rs_step = (rs_try >= {1'b0, div_r}) ? rs_sub[DIM_WIDTH-1:0] : rs_try[DIM_WIDTH-1:0];
    rc_step = (rc_try >= {1'b0, div_r}) ? rc_sub[DIM_WIDTH-1:0] : rc_try[DIM_WIDTH-1:0];

    busy    = (state_r != ST_IDLE);
    wr_en   = (state_r == ST_WRITE);
    wr_dim  = dim_r;
    wr_src  = (rc_r >= rs_r) ? (rc_r - rs_r) : (rc_r + div_r - rs_r);
    wr_zsrc = (rs_r == '0) ? '0 : (div_r - rs_r);

    state_nxt = state_r;
    dim_nxt   = dim_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
      end
      ST_LOAD: begin
        cnt_nxt   = CNT_W'(DIM_WIDTH - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (dim_r == DIM_IDX_W'(MAX_DIMS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          dim_nxt   = dim_r + 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // A further write restarts the pass from the outermost dimension.
    if (start) begin
      state_nxt = ST_LOAD;
      dim_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dim_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      dim_r   <= dim_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      div_r <= sizes[dim_r*DIM_WIDTH +: DIM_WIDTH];
      sa_r  <= shifts[dim_r*DIM_WIDTH +: DIM_WIDTH];
      ca_r  <= coords[dim_r*DIM_WIDTH +: DIM_WIDTH];
      rs_r  <= '0;
      rc_r  <= '0;
    end else if (state_r == ST_DIV) begin
      sa_r <= {sa_r[DIM_WIDTH-2:0], 1'b0};
      ca_r <= {ca_r[DIM_WIDTH-2:0], 1'b0};
      rs_r <= rs_step;
      rc_r <= rc_step;
    end
  end

endmodule

// ===== rtl/trag_cell.sv =====
// ----------------------------------------------------------------------------
// trag_cell
// One multiply-accumulate stage of the offset chain: adds this dimension's
// source coordinate times its stride to the running offset.
// ----------------------------------------------------------------------------
module trag_cell #(
  parameter int MAX_DIMS     = 4,
  parameter int DIM_WIDTH    = 16,
  parameter int OFFSET_WIDTH = 32,
  parameter int DIM_INDEX    = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [trag_pkg::POS_W-1:0]    in_pos,
  input  logic                          in_last,
  input  logic [MAX_DIMS*DIM_WIDTH-1:0] in_srcs,
  input  logic [OFFSET_WIDTH-1:0]       in_sum,
  input  logic [trag_pkg::STRIDE_W-1:0] stride,
  output logic                          out_valid,
  output logic [trag_pkg::POS_W-1:0]    out_pos,
  output logic                          out_last,
  output logic [MAX_DIMS*DIM_WIDTH-1:0] out_srcs,
  output logic [OFFSET_WIDTH-1:0]       out_sum
);
  import trag_pkg::*;

  localparam int PROD_W = DIM_WIDTH + STRIDE_W;

  logic [DIM_WIDTH-1:0]    src;
  logic [PROD_W-1:0]       prod;
  logic [OFFSET_WIDTH-1:0] prod_fit;
  logic                    valid_r;
  logic [POS_W-1:0]        pos_r;
  logic                    last_r;
  logic [MAX_DIMS*DIM_WIDTH-1:0] srcs_r;
  logic [OFFSET_WIDTH-1:0] sum_r;

  assign src  = in_srcs[DIM_INDEX*DIM_WIDTH +: DIM_WIDTH];
  assign prod = {{STRIDE_W{1'b0}}, src} * {{DIM_WIDTH{1'b0}}, stride};

  generate
    if (PROD_W >= OFFSET_WIDTH) begin : g_trunc
      assign prod_fit = prod[OFFSET_WIDTH-1:0];
    end else begin : g_ext
      assign prod_fit = {{(OFFSET_WIDTH-PROD_W){1'b0}}, prod};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r  <= in_pos;
      last_r <= in_last;
      srcs_r <= in_srcs;
      sum_r  <= in_sum + prod_fit;
    end
  end

  assign out_valid = valid_r;
  assign out_pos   = pos_r;
  assign out_last  = last_r;
  assign out_srcs  = srcs_r;
  assign out_sum   = sum_r;

endmodule

// ===== rtl/tensor_roll_address_generator.sv =====
// ----------------------------------------------------------------------------
// tensor_roll_address_generator
// Walks the output coordinates of a rolled tensor, last dimension fastest,
// and returns for each step the output position, source offset and last flag.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | tvalid / tready    | tdata: restart
//  out_    | output    | tvalid / tready    | tdata: position, offset; tlast
//  cfg_    | input     | wr_en (no wait)    | index, data
//
// One word is taken per cycle while in_tready is high; each then passes through
// the chain of multiply-accumulate cells, the last of which is the output register.
// A write to the sizes or shifts starts a renormalizing pass during which
// in_tready is low. A stalled output word freezes the whole chain and
// in_tready drops with it. Reset is synchronous and restores the register
// defaults and position zero.
`include "tensor_roll_address_generator_defines.svh"

module tensor_roll_address_generator #(
  parameter int MAX_DIMS     = 4,
  parameter int DIM_WIDTH    = 16,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [0] restart, [7:1] zero
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [63:0]                     out_tdata,  // [31:0] out_position,
                                                      // [63:32] source_offset
  output logic                            out_tlast,
  input  logic                            cfg_wr_en,
  input  logic [trag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trag_pkg::CFG_DATA_W-1:0] cfg_data
);
  import trag_pkg::*;

  localparam int DIM_IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  // Every dimension field that fits in the register starts at size one.
  function automatic logic [CFG_DATA_W-1:0] sizes_rst_val();
    logic [CFG_DATA_W-1:0] v;
    v = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if ((MAX_DIMS - 1 - d) * DIM_WIDTH < CFG_DATA_W) begin
        v[(MAX_DIMS - 1 - d) * DIM_WIDTH] = 1'b1;
      end
    end
    return v;
  endfunction

  localparam logic [CFG_DATA_W-1:0] SIZES_RST = sizes_rst_val();

  logic [CFG_DATA_W-1:0] sizes_r, shifts_r;
  logic [STRIDE_W-1:0]   stride_r [NUM_STRIDES];

  logic [DIM_WIDTH-1:0] size_field  [MAX_DIMS];
  logic [DIM_WIDTH-1:0] shift_field [MAX_DIMS];
  logic [DIM_WIDTH-1:0] size_fix    [MAX_DIMS];
  logic [STRIDE_W-1:0]  stride_dim  [MAX_DIMS];
  logic [MAX_DIMS*DIM_WIDTH-1:0] size_flat, shift_flat, coord_flat, src_flat;
  logic [MAX_DIMS:0] full_chain;

  logic                 norm_start, norm_busy, norm_wr_en;
  logic [DIM_IDX_W-1:0] norm_wr_dim;
  logic [DIM_WIDTH-1:0] norm_wr_src, norm_wr_zsrc;

  logic       en, accept, is_last;
  trag_ctl_t  ctl;
  logic [POS_W-1:0] pos_r, pos_nxt, cur_pos;

  logic                          cv    [MAX_DIMS+1];
  logic [POS_W-1:0]              cpos  [MAX_DIMS+1];
  logic                          clast [MAX_DIMS+1];
  logic [MAX_DIMS*DIM_WIDTH-1:0] csrcs [MAX_DIMS+1];
  logic [OFFSET_WIDTH-1:0]       csum  [MAX_DIMS+1];
  logic [OUT_OFS_W-1:0]          ofs_out;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sizes_r     <= SIZES_RST;
      shifts_r    <= '0;
      stride_r[0] <= '0;
      stride_r[1] <= '0;
      stride_r[2] <= '0;
      stride_r[3] <= STRIDE_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SIZES:    sizes_r     <= cfg_data;
        CFG_SHIFTS:   shifts_r    <= cfg_data;
        CFG_STRIDE_0: stride_r[0] <= cfg_data[STRIDE_W-1:0];
        CFG_STRIDE_1: stride_r[1] <= cfg_data[STRIDE_W-1:0];
        CFG_STRIDE_2: stride_r[2] <= cfg_data[STRIDE_W-1:0];
        CFG_STRIDE_3: stride_r[3] <= cfg_data[STRIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign norm_start = cfg_wr_en && ((cfg_index == CFG_SIZES) || (cfg_index == CFG_SHIFTS));

  // Per-dimension fields; dimension 0 sits in the top field, and bits beyond
  // the register read as zero.
  generate
    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
      localparam int SH = (MAX_DIMS - 1 - d) * DIM_WIDTH;
      for (genvar b = 0; b < DIM_WIDTH; b++) begin : g_bit
        if (SH + b < CFG_DATA_W) begin : g_in
          assign size_field[d][b]  = sizes_r[SH+b];
          assign shift_field[d][b] = shifts_r[SH+b];
        end else begin : g_out
          assign size_field[d][b]  = 1'b0;
          assign shift_field[d][b] = 1'b0;
        end
      end
      assign size_fix[d] = (size_field[d] == '0) ? DIM_WIDTH'(1) : size_field[d];
      assign size_flat[d*DIM_WIDTH +: DIM_WIDTH]  = size_fix[d];
      assign shift_flat[d*DIM_WIDTH +: DIM_WIDTH] = shift_field[d];
      if (d < NUM_STRIDES) begin : g_str
        assign stride_dim[d] = stride_r[d];
      end else begin : g_nostr
        assign stride_dim[d] = '0;
      end

      trag_digit #(
        .DIM_WIDTH (DIM_WIDTH)
      ) u_digit (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .load_en     (norm_wr_en && (norm_wr_dim == DIM_IDX_W'(d))),
        .load_src    (norm_wr_src),
        .load_zsrc   (norm_wr_zsrc),
        .size        (size_fix[d]),
        .low_full_in (full_chain[d+1]),
        .full_out    (full_chain[d]),
        .coord       (coord_flat[d*DIM_WIDTH +: DIM_WIDTH]),
        .cur_src     (src_flat[d*DIM_WIDTH +: DIM_WIDTH])
      );
    end
  endgenerate

  assign full_chain[MAX_DIMS] = 1'b1;
  assign is_last = full_chain[0];

  trag_norm #(
    .MAX_DIMS  (MAX_DIMS),
    .DIM_WIDTH (DIM_WIDTH),
    .DIM_IDX_W (DIM_IDX_W)
  ) u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (norm_start),
    .sizes   (size_flat),
    .shifts  (shift_flat),
    .coords  (coord_flat),
    .busy    (norm_busy),
    .wr_en   (norm_wr_en),
    .wr_dim  (norm_wr_dim),
    .wr_src  (norm_wr_src),
    .wr_zsrc (norm_wr_zsrc)
  );

  // The chain moves whenever the output register is free or being drained.
  assign en          = !cv[MAX_DIMS] || out_tready;
  assign in_tready   = en && !norm_busy;
  assign accept      = in_tvalid && in_tready;
  assign ctl.step    = accept;
  assign ctl.restart = accept && in_tdata[0];

  always_comb begin
    cur_pos = ctl.restart ? '0 : pos_r;
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = is_last ? '0 : (cur_pos + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  assign cv[0]    = accept;
  assign cpos[0]  = cur_pos;
  assign clast[0] = is_last;
  assign csrcs[0] = src_flat;
  assign csum[0]  = '0;

  generate
    for (genvar k = 0; k < MAX_DIMS; k++) begin : g_cell
      trag_cell #(
        .MAX_DIMS     (MAX_DIMS),
        .DIM_WIDTH    (DIM_WIDTH),
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .DIM_INDEX    (k)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cv[k]),
        .in_pos    (cpos[k]),
        .in_last   (clast[k]),
        .in_srcs   (csrcs[k]),
        .in_sum    (csum[k]),
        .stride    (stride_dim[k]),
        .out_valid (cv[k+1]),
        .out_pos   (cpos[k+1]),
        .out_last  (clast[k+1]),
        .out_srcs  (csrcs[k+1]),
        .out_sum   (csum[k+1])
      );
    end

    if (OFFSET_WIDTH >= OUT_OFS_W) begin : g_ofs_cut
      assign ofs_out = csum[MAX_DIMS][OUT_OFS_W-1:0];
    end else begin : g_ofs_ext
      assign ofs_out = {{(OUT_OFS_W-OFFSET_WIDTH){1'b0}}, csum[MAX_DIMS]};
    end
  endgenerate

  assign out_tvalid = cv[MAX_DIMS];
  assign out_tdata  = {ofs_out, cpos[MAX_DIMS]};
  assign out_tlast  = clast[MAX_DIMS];

  `TRAG_ASSERT_NEXT(a_last_wraps_position, accept && is_last, pos_r == '0, "position did not wrap after last word")
  `TRAG_ASSERT_NEXT(a_cfg_starts_norm, norm_start, norm_busy, "size or shift write did not start renormalizing")
  `TRAG_ASSERT_SAME(a_stall_blocks_input, out_tvalid && !out_tready, !in_tready, "input taken while output stalled")
  `TRAG_ASSERT_SAME(a_no_accept_in_norm, norm_busy, !accept, "word accepted during renormalizing")

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Roll address generator testbench
// Drives step requests through the stream ports and reprograms sizes, shifts
// and strides between phases. An odometer model of the circular roll predicts
// every word; each output word is checked against it or against a fixed value.
// A short table covers reset values, extremes and corner cases, then random
// phases follow with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import trag_pkg::*;

  localparam int DIMS = 4;
  localparam int DIM_W = 16;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int TARGET_WORDS = 900;
  localparam int QUIET_WORDS = 150;

  // Indexes with no register behind them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [POS_W-1:0]     position;
    logic [OUT_OFS_W-1:0] offset;
    logic                 is_last;
  } addr_result_t;

  typedef enum logic {ROW_WRITE, ROW_STEP} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
    logic                  restart;
    logic                  typed;
    addr_result_t          want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'd0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [63:0]           out_tdata;
  logic                  out_tlast;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SIZES;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tensor_roll_address_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Odometer model, starting from the reset values.
  logic [CFG_DATA_W-1:0] sizes_reg = 64'h0001_0001_0001_0001;
  logic [CFG_DATA_W-1:0] shifts_reg = '0;
  logic [STRIDE_W-1:0]   stride_reg [DIMS] = '{32'd0, 32'd0, 32'd0, 32'd1};
  logic [DIM_W-1:0]      coord [DIMS] = '{16'd0, 16'd0, 16'd0, 16'd0};
  logic [POS_W-1:0]      pos_count = '0;

  addr_result_t expected_q [$];
  plan_row_t    plan_q [$];
  int unsigned  word_count = 0;
  int unsigned  fail_count = 0;
  int unsigned  snd_run = 0;
  int unsigned  rd_gap = 0;
  int unsigned  rd_run = 0;
  bit           quiet = 1'b0;
  bit           hold_go = 1'b0;
  logic         long_hold = 1'b0;

  // Dimension 0 sits in the top field; a zero size counts as one.
  function automatic int unsigned dim_size(int d);
    logic [DIM_W-1:0] field;
    field = sizes_reg[(DIMS-1-d)*DIM_W +: DIM_W];
    return (field == 0) ? 1 : field;
  endfunction

  function automatic addr_result_t roll_step(logic restart);
    addr_result_t r;
    int unsigned  sz, amt, c, src;
    logic         carry;
    r.offset = '0;
    r.is_last = 1'b1;
    if (restart) begin
      for (int d = 0; d < DIMS; d++) coord[d] = '0;
      pos_count = '0;
    end
    for (int d = DIMS - 1; d >= 0; d--) begin
      sz = dim_size(d);
      amt = shifts_reg[(DIMS-1-d)*DIM_W +: DIM_W] % sz;
      c = coord[d] % sz;
      src = (c >= amt) ? c - amt : c + sz - amt;
      r.offset += src * stride_reg[d];
      if (coord[d] < sz - 1) r.is_last = 1'b0;
    end
    r.position = pos_count;
    if (r.is_last) begin
      for (int d = 0; d < DIMS; d++) coord[d] = '0;
      pos_count = '0;
    end else begin
      // A digit left above its size by a resize carries out and clears.
      carry = 1'b1;
      for (int d = DIMS - 1; d >= 0; d--) begin
        if (carry) begin
          if (coord[d] + 1 < dim_size(d)) begin
            coord[d] = coord[d] + 1'b1;
            carry = 1'b0;
          end else begin
            coord[d] = '0;
          end
        end
      end
      pos_count = pos_count + 1'b1;
    end
    return r;
  endfunction

  function automatic void plan_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.index = idx;
    row.value = val;
    plan_q.push_back(row);
  endfunction

  function automatic void plan_step(logic restart);
    plan_row_t row;
    row = '0;
    row.kind = ROW_STEP;
    row.restart = restart;
    plan_q.push_back(row);
  endfunction

  function automatic void plan_fixed(logic restart, logic [POS_W-1:0] pos,
                                     logic [OUT_OFS_W-1:0] ofs, logic fin);
    plan_row_t row;
    row = '0;
    row.kind = ROW_STEP;
    row.restart = restart;
    row.typed = 1'b1;
    row.want = '{position: pos, offset: ofs, is_last: fin};
    plan_q.push_back(row);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_SIZES:    sizes_reg = val;
      CFG_SHIFTS:   shifts_reg = val;
      CFG_STRIDE_0: stride_reg[0] = val[STRIDE_W-1:0];
      CFG_STRIDE_1: stride_reg[1] = val[STRIDE_W-1:0];
      CFG_STRIDE_2: stride_reg[2] = val[STRIDE_W-1:0];
      CFG_STRIDE_3: stride_reg[3] = val[STRIDE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Stop offering words and let every expected word come out.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Called at a clock edge; returns at the edge that accepted the word or
  // after the idle gap that follows it. tvalid stays high between words unless an idle gap drops it.
  task automatic send_word(logic restart, logic typed, addr_result_t want);
    addr_result_t got;
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, restart};
    do @(posedge clk); while (!in_tready);
    got = roll_step(restart);
    expected_q.push_back(typed ? want : got);
    word_count++;
    if (!quiet) begin
      if (snd_run != 0) begin
        snd_run--;
      end else if ($urandom_range(0, 2) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        snd_run = $urandom_range(0, 10);
      end else begin
        snd_run = $urandom_range(5, 60);
      end
    end
  endtask

  // Output side: random stall bursts, stretches without stalls, and the
  // long hold-off counted in its own process below.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      rd_gap = 0;
    end else if (rd_gap != 0) begin
      rd_gap--;
    end else if (rd_run != 0) begin
      rd_run--;
    end else if ($urandom_range(0, 3) == 0) begin
      rd_run = $urandom_range(20, 200);
    end else begin
      rd_gap = $urandom_range(1, 18);
      rd_run = $urandom_range(1, 12);
    end
    out_tready <= rst_n && !long_hold && (rd_gap == 0);
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin : check_words
    addr_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word: position %0d offset %h last %b", $time,
                 out_tdata[31:0], out_tdata[63:32], out_tlast);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_tdata[31:0] !== want.position) begin
          $display("%0t: position mismatch: expected %0d, actual %0d", $time,
                   want.position, out_tdata[31:0]);
          fail_count++;
        end
        if (out_tdata[63:32] !== want.offset) begin
          $display("%0t: offset mismatch at position %0d: expected %h, actual %h", $time,
                   want.position, want.offset, out_tdata[63:32]);
          fail_count++;
        end
        if (out_tlast !== want.is_last) begin
          $display("%0t: last mismatch at position %0d: expected %b, actual %b", $time,
                   want.position, want.is_last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    plan_row_t             row;
    logic [CFG_DATA_W-1:0] sizes_val, shifts_val;
    logic [STRIDE_W-1:0]   stride_val;
    int unsigned           sz, pick;
    bit                    first_phase;

    // After reset every size is one, so each word is the last one at zero.
    plan_fixed(1'b0, 32'd0, 32'd0, 1'b1);
    plan_fixed(1'b1, 32'd0, 32'd0, 1'b1);
    // Small tensor; the third dimension's shift exceeds its size.
    plan_write(CFG_SIZES, 64'h0002_0003_0004_0005);
    plan_write(CFG_SHIFTS, 64'h0001_0002_0006_0004);
    plan_write(CFG_STRIDE_0, 64'd60);
    plan_write(CFG_STRIDE_1, 64'd20);
    plan_write(CFG_STRIDE_2, 64'd5);
    plan_write(CFG_STRIDE_3, 64'd1);
    plan_step(1'b1);
    repeat (6) plan_step(1'b0);
    // Zero sizes read as one.
    plan_write(CFG_SIZES, 64'd0);
    plan_fixed(1'b1, 32'd0, 32'd0, 1'b1);
    plan_fixed(1'b0, 32'd0, 32'd0, 1'b1);
    // Largest sizes and strides with large shifts; the offset wraps.
    plan_write(CFG_SIZES, 64'hFFFF_FFFF_FFFF_FFFF);
    plan_write(CFG_SHIFTS, 64'hFFFF_FFFE_0001_8000);
    plan_write(CFG_STRIDE_0, 64'hFFFF_FFFF_FFFF_FFFF);
    plan_write(CFG_STRIDE_1, 64'h0000_0000_FFFF_FFFF);
    plan_write(CFG_STRIDE_2, 64'h1234_5678_FFFF_FFFF);
    plan_write(CFG_STRIDE_3, 64'h0000_0000_FFFF_FFFF);
    plan_step(1'b1);
    repeat (3) plan_step(1'b0);
    // Writes to indexes with no register are ignored.
    plan_write(CFG_SPARE_LO, 64'hDEAD_BEEF_0000_0001);
    plan_write(CFG_SPARE_HI, 64'h0000_0000_0000_0000);
    repeat (2) plan_step(1'b0);
    // Shrink a dimension mid-walk so its digit sits above the new size.
    plan_write(CFG_SIZES, 64'h0001_0001_0001_0008);
    plan_write(CFG_SHIFTS, 64'd0);
    plan_write(CFG_STRIDE_3, 64'd3);
    plan_step(1'b1);
    repeat (5) plan_step(1'b0);
    plan_write(CFG_SIZES, 64'h0001_0001_0002_0003);
    repeat (2) plan_step(1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan_q[i]) begin
      row = plan_q[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_reg(row.index, row.value);
      end else begin
        send_word(row.restart, row.typed, row.want);
      end
    end

    // Random phases: new settings, then a run of mostly continuing steps so
    // that walks complete, with an occasional restart.
    first_phase = 1'b1;
    while (word_count < TARGET_WORDS) begin
      settle();
      sizes_val = '0;
      shifts_val = '0;
      for (int d = 0; d < DIMS; d++) begin
        pick = $urandom_range(0, 15);
        if (pick == 0) sz = 0;
        else if (pick == 1) sz = 16'hFFFF;
        else if (pick == 2) sz = $urandom_range(1, 16'hFFFF);
        else if (pick < 6) sz = $urandom_range(4, 6);
        else sz = $urandom_range(1, 3);
        sizes_val[(DIMS-1-d)*DIM_W +: DIM_W] = DIM_W'(sz);
        if ($urandom_range(0, 1) == 0)
          shifts_val[(DIMS-1-d)*DIM_W +: DIM_W] =
            DIM_W'($urandom_range(0, (sz == 0) ? 0 : sz - 1));
        else
          shifts_val[(DIMS-1-d)*DIM_W +: DIM_W] = DIM_W'($urandom_range(0, 16'hFFFF));
      end
      if (first_phase || $urandom_range(0, 1) == 0) write_reg(CFG_SIZES, sizes_val);
      if (first_phase || $urandom_range(0, 1) == 0) write_reg(CFG_SHIFTS, shifts_val);
      for (int d = 0; d < DIMS; d++) begin
        pick = $urandom_range(0, 3);
        if (pick == 0) stride_val = $urandom;
        else if (pick == 1) stride_val = 32'hFFFF_FFFF - $urandom_range(0, 15);
        else stride_val = $urandom_range(0, 64);
        if (first_phase || $urandom_range(0, 1) == 0)
          write_reg(CFG_IDX_W'(CFG_STRIDE_0 + d), {$urandom, stride_val});
      end
      if ($urandom_range(0, 7) == 0)
        write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI, {$urandom, $urandom});
      // The first phase runs into the long output stall, so the chain fills.
      if (first_phase) hold_go = 1'b1;
      first_phase = 1'b0;
      repeat ($urandom_range(10, 80)) begin
        if (word_count >= TARGET_WORDS - QUIET_WORDS) quiet = 1'b1;
        send_word($urandom_range(0, 39) == 0, 1'b0, '0);
      end
    end

    settle();
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
